// File: design/rxrb_pkg.sv
// ----------------------------------------------------------------------------
// rxrb_pkg
// Shared types and constants for the receive ring buffer with statistics.
// ----------------------------------------------------------------------------
package rxrb_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam logic [3:0]  ERR_FLAG_MASK    = 4'h0f;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned FLAGS_W  = 4;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned COUNT_W  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX   = 2'd0,
    CMD_POP  = 2'd1,
    CMD_INTR = 2'd2
  } cmd_t;

  // Events of one accepted item, as seen by the statistics counters.
  typedef struct packed {
    logic byte_rx;
    logic line_err;
    logic overflow;
    logic intr;
  } stat_evt_t;

  // Outcome of one accepted item, as seen by the buffer control.
  typedef struct packed {
    logic stored;
    logic popped;
  } buf_status_t;

endpackage

// File: design/rxrb_in_if.sv
// ----------------------------------------------------------------------------
// rxrb_in_if
// Input channel: command, received byte and line error flags.
// ----------------------------------------------------------------------------
interface rxrb_in_if;
  logic                               valid;
  logic                               ready;
  logic [rxrb_pkg::CMD_W-1:0]         command;
  logic [rxrb_pkg::DATA_W-1:0]        rx_data;
  logic [rxrb_pkg::FLAGS_W-1:0]       rx_error_flags;

  modport source (output valid, output command, output rx_data, output rx_error_flags,
                  input ready);
  modport sink   (input valid, input command, input rx_data, input rx_error_flags,
                  output ready);
endinterface

// File: design/rxrb_out_if.sv
// ----------------------------------------------------------------------------
// rxrb_out_if
// Result channel: pop outcome, fill levels and statistics counters.
// ----------------------------------------------------------------------------
interface rxrb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pop_ok;
  logic [rxrb_pkg::DATA_W-1:0]   pop_byte;
  logic                          push_accepted;
  logic [rxrb_pkg::LEVEL_W-1:0]  fill_level;
  logic [rxrb_pkg::LEVEL_W-1:0]  peak_fill;
  logic [rxrb_pkg::COUNT_W-1:0]  bytes_seen;
  logic [rxrb_pkg::COUNT_W-1:0]  overflows_seen;
  logic [rxrb_pkg::COUNT_W-1:0]  errors_seen;
  logic [rxrb_pkg::COUNT_W-1:0]  interrupts_seen;

  modport source (output valid, output pop_ok, output pop_byte, output push_accepted,
                  output fill_level, output peak_fill, output bytes_seen,
                  output overflows_seen, output errors_seen, output interrupts_seen,
                  input ready);
  modport sink   (input valid, input pop_ok, input pop_byte, input push_accepted,
                  input fill_level, input peak_fill, input bytes_seen,
                  input overflows_seen, input errors_seen, input interrupts_seen,
                  output ready);
endinterface

// File: design/rx_ring_buffer_with_stats.sv
// ----------------------------------------------------------------------------
// rx_ring_buffer_with_stats
// Receive byte ring buffer with fill, peak and event statistics.
// ----------------------------------------------------------------------------
// Usage:
// Each item on in_ch carries a command: receive a byte (with its line error
// flags), pop the oldest byte, or count an interrupt. Every accepted item
// yields exactly one result on out_ch, in order, showing the pop outcome,
// whether the byte was stored, the fill level, the peak level and the four
// 64-bit wrapping counters as they stand after that item.
// The result is registered: it is valid in the cycle after acceptance.
// Throughput is one item per cycle unless out_ch stalls; the state update,
// the memory write and the registered memory read complete at the accepting edge.
// A pending result is held until out_ch takes it; in_ch stays ready while
// out_ch is ready, so a new item is taken in the same cycle a result leaves.
// While a result waits and the receiver stalls, in_ch is not ready and
// nothing changes; with no result waiting, one item is still taken.
// Synchronous reset empties the buffer and clears the peak and all counters;
// the byte store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rx_ring_buffer_with_stats #(
  parameter int unsigned BUFFER_DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rxrb_in_if.sink     in_ch,
  rxrb_out_if.source  out_ch
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned LVL_W  = $clog2(BUFFER_DEPTH + 1);

  logic                         accept;
  rxrb_pkg::cmd_t               cmd;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [rxrb_pkg::DATA_W-1:0]  rd_data;
  logic                         full;
  rxrb_pkg::buf_status_t        status;
  rxrb_pkg::stat_evt_t          evt;
  logic [LVL_W-1:0]             level;
  logic [LVL_W-1:0]             peak;
  logic [31:0]                  level_w;
  logic [31:0]                  peak_w;

  logic                         out_valid_r, out_valid_nxt;
  logic                         pop_ok_r;
  logic                         push_ok_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = rxrb_pkg::cmd_t'(in_ch.command);

  always_comb begin
    evt          = '0;
    evt.byte_rx  = accept && (cmd == rxrb_pkg::CMD_RX);
    evt.line_err = evt.byte_rx &&
                   ((in_ch.rx_error_flags & rxrb_pkg::ERR_FLAG_MASK) != '0);
    evt.overflow = evt.byte_rx && full;
    evt.intr     = accept && (cmd == rxrb_pkg::CMD_INTR);
  end

  rxrb_ctrl #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W),
    .LVL_W  (LVL_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .full    (full),
    .status  (status),
    .level   (level),
    .peak    (peak)
  );

  rxrb_ram #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.rx_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rxrb_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .bytes_cnt (out_ch.bytes_seen),
    .ovf_cnt   (out_ch.overflows_seen),
    .err_cnt   (out_ch.errors_seen),
    .intr_cnt  (out_ch.interrupts_seen)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_ok_r  <= status.popped;
      push_ok_r <= status.stored;
    end
  end

  // The level, peak and counter registers only move on acceptance, so they
  // already hold the values of the pending result and serve as its fields.
  assign level_w = 32'(level);
  assign peak_w  = 32'(peak);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pop_ok        = pop_ok_r;
  assign out_ch.pop_byte      = pop_ok_r ? rd_data : '0;
  assign out_ch.push_accepted = push_ok_r;
  assign out_ch.fill_level    = level_w[rxrb_pkg::LEVEL_W-1:0];
  assign out_ch.peak_fill     = peak_w[rxrb_pkg::LEVEL_W-1:0];

endmodule

// File: design/rxrb_ram.sv
// ----------------------------------------------------------------------------
// rxrb_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rxrb_ram #(
  parameter int unsigned DEPTH  = rxrb_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [rxrb_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [rxrb_pkg::DATA_W-1:0] rd_data
);

  logic [rxrb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rxrb_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/rxrb_ctrl.sv
// ----------------------------------------------------------------------------
// rxrb_ctrl
// Ring buffer control: slot pointers, fill level and peak level.
// ----------------------------------------------------------------------------
module rxrb_ctrl #(
  parameter int unsigned DEPTH  = rxrb_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned LVL_W  = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  rxrb_pkg::cmd_t        cmd,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  output logic                  full,
  output rxrb_pkg::buf_status_t status,
  output logic [LVL_W-1:0]      level,
  output logic [LVL_W-1:0]      peak
);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [LVL_W-1:0]  FULL_LVL  = LVL_W'(DEPTH);

  logic [ADDR_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [ADDR_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [LVL_W-1:0]  peak_r, peak_nxt;
  logic              empty;

  assign full  = (level_r == FULL_LVL);
  assign empty = (level_r == '0);

  always_comb begin
    status      = '0;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    level_nxt   = level_r;
    peak_nxt    = peak_r;
    if (accept) begin
      case (cmd)
        rxrb_pkg::CMD_RX: begin
          if (!full) begin
            status.stored = 1'b1;
            wr_slot_nxt   = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
            level_nxt     = level_r + 1'b1;
            if (level_nxt > peak_r) begin
              peak_nxt = level_nxt;
            end
          end
        end
        rxrb_pkg::CMD_POP: begin
          if (!empty) begin
            status.popped = 1'b1;
            rd_slot_nxt   = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
            level_nxt     = level_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      level_r   <= '0;
      peak_r    <= '0;
    end else begin
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      level_r   <= level_nxt;
      peak_r    <= peak_nxt;
    end
  end

  assign wr_en   = status.stored;
  assign wr_addr = wr_slot_r;
  assign rd_en   = status.popped;
  assign rd_addr = rd_slot_r;
  assign level   = level_r;
  assign peak    = peak_r;

endmodule

// File: design/rxrb_stats.sv
// ----------------------------------------------------------------------------
// rxrb_stats
// Wrapping 64-bit counters for received bytes, overflows, errors, interrupts.
// ----------------------------------------------------------------------------
module rxrb_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rxrb_pkg::stat_evt_t           evt,
  output logic [rxrb_pkg::COUNT_W-1:0]  bytes_cnt,
  output logic [rxrb_pkg::COUNT_W-1:0]  ovf_cnt,
  output logic [rxrb_pkg::COUNT_W-1:0]  err_cnt,
  output logic [rxrb_pkg::COUNT_W-1:0]  intr_cnt
);

  logic [rxrb_pkg::COUNT_W-1:0] bytes_r, bytes_nxt;
  logic [rxrb_pkg::COUNT_W-1:0] ovf_r, ovf_nxt;
  logic [rxrb_pkg::COUNT_W-1:0] err_r, err_nxt;
  logic [rxrb_pkg::COUNT_W-1:0] intr_r, intr_nxt;

  always_comb begin
    bytes_nxt = evt.byte_rx  ? bytes_r + 1'b1 : bytes_r;
    ovf_nxt   = evt.overflow ? ovf_r + 1'b1   : ovf_r;
    err_nxt   = evt.line_err ? err_r + 1'b1   : err_r;
    intr_nxt  = evt.intr     ? intr_r + 1'b1  : intr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      ovf_r   <= '0;
      err_r   <= '0;
      intr_r  <= '0;
    end else begin
      bytes_r <= bytes_nxt;
      ovf_r   <= ovf_nxt;
      err_r   <= err_nxt;
      intr_r  <= intr_nxt;
    end
  end

  assign bytes_cnt = bytes_r;
  assign ovf_cnt   = ovf_r;
  assign err_cnt   = err_r;
  assign intr_cnt  = intr_r;

endmodule
